FILE: hdl/vr_pkg.sv
`default_nettype none

package vr_pkg;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [15:0]        index_ratio;
   } vr_req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic               clipped;
   } vr_rsp_type;

   // Per-item data that rides along the square root chain.
   typedef struct packed {
      logic [2:0][15:0] norm;
      logic [2:0][15:0] perp;
      logic             clip;
   } vr_side_type;

   localparam int VEC_LEN = 3;

endpackage

`default_nettype wire

FILE: hdl/vr_if.sv
`default_nettype none

interface vr_req_if import vr_pkg::*;;
   logic       valid;
   logic       ready;
   vr_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vr_rsp_if import vr_pkg::*;;
   logic       valid;
   logic       ready;
   vr_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vr_root_cell.sv
`default_nettype none

module vr_root_cell import vr_pkg::*; #(
   parameter int RB   = 18,
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_i,
   input  vr_side_type       side_i,
   input  logic [2*RB-1:0]   mag_i,
   input  logic [RB+2:0]     rem_i,
   input  logic [RB-1:0]     root_i,
   output logic              valid_o,
   output vr_side_type       side_o,
   output logic [2*RB-1:0]   mag_o,
   output logic [RB+2:0]     rem_o,
   output logic [RB-1:0]     root_o
);

   localparam int RW  = RB + 3;
   localparam int LSB = 2 * (RB - 1 - STEP);

   logic          valid_ff;
   vr_side_type   side_ff;
   logic [2*RB-1:0] mag_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RB-1:0] root_ff, root_in;
   logic [RW-1:0] cur_w, trial_w;

   // One result bit per cell: bring down the next pair of bits and try 4q+1.
   always_comb begin
      cur_w   = {rem_i[RW-3:0], mag_i[LSB+1:LSB]};
      trial_w = RW'({root_i, 2'b01});
      if (cur_w >= trial_w) begin
         rem_in  = cur_w - trial_w;
         root_in = {root_i[RB-2:0], 1'b1};
      end else begin
         rem_in  = cur_w;
         root_in = {root_i[RB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_i;
         mag_ff  <= mag_i;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign valid_o = valid_ff;
   assign side_o  = side_ff;
   assign mag_o   = mag_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;

endmodule

`default_nettype wire

FILE: hdl/vector3_refract.sv
// Channel  Dir  Handshake          Payload
// req_ch   in   valid/ready        dir, norm (Q3.12), index_ratio (Q4.12)
// rsp_ch   out  valid/ready        out_x/y/z (Q3.12), clipped
//
// One item enters per cycle while the pipe is not stalled. Its result passes
// the numbered stages, RB square root cells, one per root bit, and stages A
// and B into the output register; RB is half the larger of 2*F+2 and 34.
// Reset is synchronous and clears only valid bits.
// A stalled result waits in the output register; the pipe keeps moving and
// taking items until its last stage also holds a finished item.
`default_nettype none

module vector3_refract import vr_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input logic      clock,
   input logic      reset,
   vr_req_if.sink   req_ch,
   vr_rsp_if.source rsp_ch
);

   localparam int F     = FRAC_BITS;
   localparam int ONE_W = 2 * F + 2;
   localparam int CW    = (ONE_W > 34) ? ONE_W : 34;
   localparam int NCW   = 16 + CW;
   localparam int IW    = NCW + 1;
   localparam int IFW   = IW - 2 * F;
   localparam int PRW   = IFW + 17;
   localparam int MW    = CW;
   localparam int RB    = (MW + 1) / 2;
   localparam int PW    = 2 * RB;
   localparam int RW    = RB + 3;
   localparam int NRW   = 16 + RB + 1;
   localparam int PAW   = NRW + 1;
   localparam int SW    = PAW + 1;

   localparam logic signed [CW-1:0] ONE_C =
      {{(CW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
   localparam logic signed [IW-1:0] HALF2 =
      {{(IW-2*F){1'b0}}, 1'b1, {(2*F-1){1'b0}}};
   localparam logic signed [PRW-1:0] HALF_P =
      {{(PRW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
   localparam logic signed [PAW-1:0] HALF_A =
      {{(PAW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

   logic en;
   logic [8:1] fv_ff;

   logic signed [15:0] d1_ff [VEC_LEN], n1_ff [VEC_LEN];
   logic [15:0]        r1_ff;
   logic signed [31:0] dn1_ff [VEC_LEN];

   logic signed [15:0] d2_ff [VEC_LEN], n2_ff [VEC_LEN];
   logic [15:0]        r2_ff;
   logic signed [CW-1:0] cos2_ff, cos2_in;

   logic signed [15:0] d3_ff [VEC_LEN], n3_ff [VEC_LEN];
   logic [15:0]        r3_ff;
   logic signed [NCW-1:0] ncos3_ff [VEC_LEN];

   logic signed [15:0] n4_ff [VEC_LEN];
   logic [15:0]        r4_ff;
   logic signed [IFW-1:0] inf4_ff [VEC_LEN], inf4_in [VEC_LEN];

   logic signed [15:0] n5_ff [VEC_LEN];
   logic signed [PRW-1:0] prod5_ff [VEC_LEN];

   logic signed [15:0] n6_ff [VEC_LEN];
   logic signed [15:0] perp6_ff [VEC_LEN], perp6_in [VEC_LEN];
   logic               clip6_ff, clip6_in;

   vr_side_type        side7_ff;
   logic [30:0]        sq7_ff [VEC_LEN];

   vr_side_type        side8_ff;
   logic [MW-1:0]      mag8_ff, mag8_in;

   logic               cv   [RB+1];
   vr_side_type        cside [RB+1];
   logic [PW-1:0]      cmag [RB+1];
   logic [RW-1:0]      crem [RB+1];
   logic [RB-1:0]      croot [RB+1];

   logic               va_ff;
   vr_side_type        sidea_ff;
   logic signed [NRW-1:0] nra_ff [VEC_LEN];

   logic               out_v_ff;
   vr_rsp_type         out_ff, out_in;

   // The pipe stalls only when its last stage and the output register are both full and the result is not taken.
   assign en           = !(va_ff && out_v_ff && !rsp_ch.ready);
   assign req_ch.ready = en;
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
         va_ff <= 1'b0;
      end else if (en) begin
         fv_ff <= {fv_ff[7:1], req_ch.valid};
         va_ff <= cv[RB];
      end
   end

   // Stage 1: products of matching components for the dot product.
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff[0] <= req_ch.data.dir_x;
         d1_ff[1] <= req_ch.data.dir_y;
         d1_ff[2] <= req_ch.data.dir_z;
         n1_ff[0] <= req_ch.data.norm_x;
         n1_ff[1] <= req_ch.data.norm_y;
         n1_ff[2] <= req_ch.data.norm_z;
         r1_ff    <= req_ch.data.index_ratio;
         dn1_ff[0] <= req_ch.data.dir_x * req_ch.data.norm_x;
         dn1_ff[1] <= req_ch.data.dir_y * req_ch.data.norm_y;
         dn1_ff[2] <= req_ch.data.dir_z * req_ch.data.norm_z;
      end
   end

   // Stage 2: cosine, clamped at one.
   always_comb begin
      logic signed [33:0] dot_w;
      logic signed [CW-1:0] neg_w;
      dot_w   = 34'(dn1_ff[0]) + 34'(dn1_ff[1]) + 34'(dn1_ff[2]);
      neg_w   = CW'(-dot_w);
      cos2_in = (neg_w > ONE_C) ? ONE_C : neg_w;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff   <= d1_ff;
         n2_ff   <= n1_ff;
         r2_ff   <= r1_ff;
         cos2_ff <= cos2_in;
      end
   end

   // Stage 3: norm times cosine.
   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff <= d2_ff;
         n3_ff <= n2_ff;
         r3_ff <= r2_ff;
         for (int i = 0; i < VEC_LEN; i++) begin
            ncos3_ff[i] <= n2_ff[i] * cos2_ff;
         end
      end
   end

   // Stage 4: dir + norm*cosine, rounded to F fraction bits.
   always_comb begin
      logic signed [IW-1:0] inner_w, t_w;
      for (int i = 0; i < VEC_LEN; i++) begin
         inner_w    = (IW'(d3_ff[i]) <<< (2 * F)) + IW'(ncos3_ff[i]);
         t_w        = inner_w + HALF2;
         inf4_in[i] = $signed(t_w[IW-1:2*F]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n4_ff   <= n3_ff;
         r4_ff   <= r3_ff;
         inf4_ff <= inf4_in;
      end
   end

   // Stage 5: scale by the index ratio.
   always_ff @(posedge clock) begin
      if (en) begin
         n5_ff <= n4_ff;
         for (int i = 0; i < VEC_LEN; i++) begin
            prod5_ff[i] <= inf4_ff[i] * $signed({1'b0, r4_ff});
         end
      end
   end

   // Stage 6: round and saturate the perpendicular part.
   always_comb begin
      logic signed [PRW-1:0] t_w;
      logic signed [PRW-F-1:0] p_w;
      clip6_in = 1'b0;
      for (int i = 0; i < VEC_LEN; i++) begin
         t_w = prod5_ff[i] + HALF_P;
         p_w = $signed(t_w[PRW-1:F]);
         if (p_w > 32767) begin
            perp6_in[i] = 16'sh7fff;
            clip6_in    = 1'b1;
         end else if (p_w < -32768) begin
            perp6_in[i] = 16'sh8000;
            clip6_in    = 1'b1;
         end else begin
            perp6_in[i] = p_w[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n6_ff    <= n5_ff;
         perp6_ff <= perp6_in;
         clip6_ff <= clip6_in;
      end
   end

   // Stage 7: squares of the perpendicular part.
   always_ff @(posedge clock) begin
      logic signed [31:0] sq_w;
      if (en) begin
         for (int i = 0; i < VEC_LEN; i++) begin
            sq_w             = perp6_ff[i] * perp6_ff[i];
            sq7_ff[i]        <= sq_w[30:0];
            side7_ff.norm[i] <= n6_ff[i];
            side7_ff.perp[i] <= perp6_ff[i];
         end
         side7_ff.clip <= clip6_ff;
      end
   end

   // Stage 8: magnitude of one minus the squared length.
   always_comb begin
      logic [33:0] pp_w;
      logic signed [CW:0] diff_w;
      pp_w    = 34'(sq7_ff[0]) + 34'(sq7_ff[1]) + 34'(sq7_ff[2]);
      diff_w  = {ONE_C[CW-1], ONE_C} - $signed({1'b0, CW'(pp_w)});
      mag8_in = (diff_w < 0) ? MW'(-diff_w) : MW'(diff_w);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side8_ff <= side7_ff;
         mag8_ff  <= mag8_in;
      end
   end

   assign cv[0]    = fv_ff[8];
   assign cside[0] = side8_ff;
   assign cmag[0]  = PW'(mag8_ff);
   assign crem[0]  = '0;
   assign croot[0] = '0;

   for (genvar k = 0; k < RB; k++) begin : g_root
      vr_root_cell #(
         .RB   (RB),
         .STEP (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (cv[k]),
         .side_i  (cside[k]),
         .mag_i   (cmag[k]),
         .rem_i   (crem[k]),
         .root_i  (croot[k]),
         .valid_o (cv[k+1]),
         .side_o  (cside[k+1]),
         .mag_o   (cmag[k+1]),
         .rem_o   (crem[k+1]),
         .root_o  (croot[k+1])
      );
   end

   // Stage A: norm times root.
   always_ff @(posedge clock) begin
      if (en) begin
         sidea_ff <= cside[RB];
         for (int i = 0; i < VEC_LEN; i++) begin
            nra_ff[i] <= $signed(cside[RB].norm[i]) * $signed({1'b0, croot[RB]});
         end
      end
   end

   // Stage B: parallel part, sum and saturation into the output register.
   always_comb begin
      logic signed [PAW-1:0] t_w;
      logic signed [PAW-F-1:0] para_w;
      logic signed [SW-1:0] sum_w;
      logic signed [15:0] o_w [VEC_LEN];
      logic clip_w;
      clip_w = sidea_ff.clip;
      for (int i = 0; i < VEC_LEN; i++) begin
         t_w    = -PAW'(nra_ff[i]) + HALF_A;
         para_w = $signed(t_w[PAW-1:F]);
         sum_w  = SW'($signed(sidea_ff.perp[i])) + SW'(para_w);
         if (sum_w > 32767) begin
            o_w[i] = 16'sh7fff;
            clip_w = 1'b1;
         end else if (sum_w < -32768) begin
            o_w[i] = 16'sh8000;
            clip_w = 1'b1;
         end else begin
            o_w[i] = sum_w[15:0];
         end
      end
      out_in.out_x   = o_w[0];
      out_in.out_y   = o_w[1];
      out_in.out_z   = o_w[2];
      out_in.clipped = clip_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en && va_ff) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && va_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/vr_checker.sv
`default_nettype none

module vr_checker import vr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input vr_rsp_type rsp_data
);

   // A waiting result is neither dropped nor changed.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // The input side may only back off while a result is held up.
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // No result can appear before an item has had time to pass.
   a_no_early : assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("result without an item");

endmodule

bind vector3_refract vr_checker u_vr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

`default_nettype wire
